@@ hdl/slot_table_with_compaction_unit_assert.svh @@
// Assertion macros used by the slot table command sequencer.
`ifndef SLOT_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH
`define SLOT_TABLE_WITH_COMPACTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

@@ hdl/stc_pkg.sv @@
// Shared field widths, command codes and status codes of the slot table.
package stc_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;

endpackage

@@ hdl/stc_slot_mem.sv @@
// Single-port-write, single-port-read slot memory with registered read data.
module stc_slot_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 33
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/stc_ctrl.sv @@
// Command sequencer: read-modify-write of single slots, compaction walk and clearing pass.
module stc_ctrl #(
    parameter int SLOTS       = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [stc_pkg::CAP_W-1:0]       capacity,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [stc_pkg::CMD_W-1:0]       command,
    input  logic [stc_pkg::IDX_W-1:0]       slot_index,
    input  logic [stc_pkg::VAL_W-1:0]       entry_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stc_pkg::STATUS_W-1:0]    status,
    output logic [stc_pkg::VAL_W-1:0]       read_value,
    output logic [stc_pkg::CAP_W-1:0]       occupied_count,
    output logic                            mem_rd_en,
    output logic [$clog2(SLOTS)-1:0]        mem_rd_addr,
    input  logic [HANDLE_BITS:0]            mem_rd_data,
    output logic                            mem_wr_en,
    output logic [$clog2(SLOTS)-1:0]        mem_wr_addr,
    output logic [HANDLE_BITS:0]            mem_wr_data
);

    import stc_pkg::*;

`include "slot_table_with_compaction_unit_assert.svh"

    localparam int AW    = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int HB    = HANDLE_BITS;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_MOVE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t                state_reg,     state_next;
    logic [CMD_W-1:0]      cmd_reg,       cmd_next;
    logic [IDX_W-1:0]      idx_reg,       idx_next;
    logic [HB-1:0]         val_reg,       val_next;
    logic [AW-1:0]         addr_reg,      addr_next;
    logic [CNT_W-1:0]      total_reg,     total_next;
    logic [CNT_W-1:0]      ptr_reg,       ptr_next;
    logic [CNT_W-1:0]      dst_reg,       dst_next;
    logic [CMP_W-1:0]      lim_reg,       lim_next;
    logic                  pend_reg,      pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;
    logic [VAL_W-1:0]      rdval_reg,     rdval_next;
    logic [CAP_W-1:0]      count_reg,     count_next;

    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      lim;
    logic [CMP_W-1:0]      idx_ext;
    logic [CMP_W-1:0]      tot_ext;
    logic                  out_free;
    logic                  load_out;
    logic                  slot_occ;
    logic [HB-1:0]         slot_val;

    // Capacity in use saturates at the built depth.
    assign cap_ext  = CMP_W'(capacity);
    assign lim      = (cap_ext > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_ext;
    assign idx_ext  = CMP_W'(idx_reg);
    assign tot_ext  = CMP_W'(total_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_occ = mem_rd_data[HB];
    assign slot_val = mem_rd_data[HB-1:0];

    // Next-state and memory access logic.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        lim_next       = lim_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        load_out       = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;

        case (state_reg)
            // Clearing pass after reset: every slot is marked empty.
            ST_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg[AW-1:0];
                if (ptr_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                ptr_next = ptr_reg + 1'b1;
            end

            // Accept a transaction and read its slot (for append, the slot at the count); compact reads nothing here.
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command;
                    idx_next  = slot_index;
                    val_next  = HB'(entry_value);
                    mem_rd_en = 1'b1;
                    if (command == CMD_APPEND)
                    begin
                        mem_rd_addr = total_reg[AW-1:0];
                    end
                    else
                    begin
                        mem_rd_addr = AW'(slot_index);
                    end
                    addr_next = mem_rd_addr;
                    if (command == CMD_COMPACT)
                    begin
                        mem_rd_en  = 1'b0;
                        ptr_next   = '0;
                        dst_next   = '0;
                        lim_next   = lim;
                        pend_next  = 1'b0;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            // Slot data is back: decide, write back and post the result.
            ST_EXEC:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    status_next = STAT_OK;
                    rdval_next  = '0;
                    mem_wr_addr = addr_reg;
                    case (cmd_reg)
                        CMD_GET:
                        begin
                            if (idx_ext >= lim)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else if (!slot_occ)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rdval_next = VAL_W'(slot_val);
                            end
                        end
                        CMD_SET:
                        begin
                            if (idx_ext >= lim)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = {1'b1, val_reg};
                                if (!slot_occ)
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (tot_ext >= lim || slot_occ)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = {1'b1, val_reg};
                                total_next  = total_reg + 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (idx_ext >= lim)
                            begin
                                status_next = STAT_INVALID;
                            end
                            else if (slot_occ)
                            begin
                                mem_wr_en = 1'b1;
                                if (total_reg != '0)
                                begin
                                    total_next = total_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STAT_INVALID;
                        end
                    endcase
                    count_next     = CAP_W'(total_next);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // Compaction walk: read each slot, copy occupied ones down.
            ST_MOVE:
            begin
                if (pend_reg && slot_occ)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = dst_reg[AW-1:0];
                    mem_wr_data = mem_rd_data;
                    dst_next    = dst_reg + 1'b1;
                end
                if (CMP_W'(ptr_reg) < lim_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ptr_next   = dst_reg;
                        state_next = ST_SWEEP;
                    end
                end
            end

            // Empty the slots above the packed region.
            ST_SWEEP:
            begin
                if (CMP_W'(ptr_reg) < lim_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            // Post the compaction result.
            ST_DONE:
            begin
                if (out_free)
                begin
                    status_next    = STAT_OK;
                    rdval_next     = '0;
                    count_next     = CAP_W'(total_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            total_reg     <= '0;
            ptr_reg       <= '0;
            dst_reg       <= '0;
            lim_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            rdval_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            dst_reg       <= dst_next;
            lim_reg       <= lim_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            rdval_reg     <= rdval_next;
            count_reg     <= count_next;
        end
    end

    // Transaction payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        addr_reg   <= addr_next;
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign read_value     = rdval_reg;
    assign occupied_count = count_reg;

    // The count never passes the built depth.
    `STC_ASSERT_IMPLY(a_total_bound, clk, rst_n, 1'b1, CMP_W'(total_reg) <= CMP_W'(SLOTS))
    // The count moves only when a single-slot result is posted.
    `STC_ASSERT_NEXT(a_total_hold, clk, rst_n, !load_out, $stable(total_reg))
    // During compaction the write pointer never overtakes the read pointer.
    `STC_ASSERT_IMPLY(a_move_order, clk, rst_n, state_reg == ST_MOVE, dst_reg <= ptr_reg)
    // A new result appears only out of the finishing states.
    `STC_ASSERT_IMPLY(a_result_source, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_EXEC) || $past(state_reg == ST_DONE))

endmodule

@@ hdl/slot_table_with_compaction_unit.sv @@
// Get, set, append and clear read their slot, then write back and post the result in the execute state;
// the result waits while the output stalls, and a new command is taken only once it is posted.
// Compact walks the slots below the capacity (saturated at SLOTS), copies occupied ones down and then
// empties the slots above the packed region before it posts its result; input is stalled meanwhile.
// Reset clears the count and runs a clearing pass over every slot of the slot memory, input stalled;
// the configuration port is open throughout and capacity resets to 256.
module slot_table_with_compaction_unit #(
    parameter int SLOTS       = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stc_pkg::CAP_W-1:0]       capacity,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [stc_pkg::CMD_W-1:0]       command,
    input  logic [stc_pkg::IDX_W-1:0]       slot_index,
    input  logic [stc_pkg::VAL_W-1:0]       entry_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stc_pkg::STATUS_W-1:0]    status,
    output logic [stc_pkg::VAL_W-1:0]       read_value,
    output logic [stc_pkg::CAP_W-1:0]       occupied_count
);

    import stc_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [CAP_W-1:0]     capacity_reg;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [HANDLE_BITS:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [HANDLE_BITS:0] mem_wr_data;

    // Capacity register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    // Command sequencer.
    stc_ctrl #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity       (capacity_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .slot_index     (slot_index),
        .entry_value    (entry_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .occupied_count (occupied_count),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data)
    );

    // Slot memory: occupied mark above the handle.
    stc_slot_mem #(
        .DEPTH (SLOTS),
        .WIDTH (HANDLE_BITS + 1)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule
